// ===== rtl/iec_pkg.sv =====
// Shared constants and types for the emissivity correction unit.
// Depends on nothing; every other file uses it by scoped names.
`timescale 1ns / 1ps

package iec_pkg;

    // Field widths.
    localparam int TEMP_W = 17;
    localparam int EMIS_W = 16;

    // Kelvin magnitude, its square and its fourth power.
    localparam int ABS_W = 17;
    localparam int SQ_W  = 2 * ABS_W;
    localparam int P4_W  = 2 * SQ_W;

    // Long division of the scaled difference by the emissivity.
    localparam int DIV_W = P4_W + EMIS_W;
    localparam int SUM_W = DIV_W + 1;

    // Radiance sum is clamped to this many bits before the roots.
    localparam int POWER_WIDTH = 72;
    localparam int ROOT1_W     = POWER_WIDTH / 2;
    localparam int ROOT2_W     = ROOT1_W / 2;

    localparam int KELVIN_OFFSET = 27315;
    localparam int OUT_MAX       = 65535;

    // Configuration register.
    localparam logic [EMIS_W-1:0] EMIS_RESET = 16'd64225;
    localparam logic REG_EMISSIVITY = 1'b0;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified item handed from the front part to the back part.
    typedef struct packed {
        logic [P4_W-1:0] ta4;
        logic [P4_W-1:0] mag;
        logic            neg;
    } work_t;

endpackage

// ===== rtl/iec_in_if.sv =====
// Input channel: ambient and raw object temperature beats.
// Depends on iec_pkg for field widths.
`timescale 1ns / 1ps

interface iec_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [iec_pkg::TEMP_W-1:0]   ambient_temp;
    logic signed [iec_pkg::TEMP_W-1:0]   object_temp;

    modport source (output valid, output ambient_temp, output object_temp, input ready);
    modport sink   (input valid, input ambient_temp, input object_temp, output ready);
endinterface

// ===== rtl/iec_out_if.sv =====
// Output channel: corrected temperature beats.
// Depends on iec_pkg for field widths.
`timescale 1ns / 1ps

interface iec_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [iec_pkg::TEMP_W-1:0]   corrected_temp;
    logic                                invalid;

    modport source (output valid, output corrected_temp, output invalid, input ready);
    modport sink   (input valid, input corrected_temp, input invalid, output ready);
endinterface

// ===== rtl/iec_front.sv =====
// Front part: accepts input beats, forms the fourth powers and classifies the difference.
// Depends on iec_pkg and iec_in_if.
`timescale 1ns / 1ps

module iec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    iec_in_if.sink               in_ch,
    input  logic                 queue_full,
    output logic                 push,
    output iec_pkg::work_t       push_data
);

    logic [3:0]                     v_reg;
    logic                           adv;
    logic [iec_pkg::ABS_W-1:0]      ka_reg, ko_reg;
    logic [iec_pkg::SQ_W-1:0]       sa_reg, so_reg;
    logic [iec_pkg::P4_W-1:0]       pa_reg, po_reg;
    iec_pkg::work_t                 w_reg;
    iec_pkg::work_t                 w_next;

    // Magnitude of the temperature in 0.01 K.
    function automatic logic [iec_pkg::ABS_W-1:0] kelvin_abs(
        input logic [iec_pkg::TEMP_W-1:0] t);
        logic [iec_pkg::TEMP_W:0] k;
        logic [iec_pkg::TEMP_W:0] m;
        k = {t[iec_pkg::TEMP_W-1], t} + (iec_pkg::TEMP_W+1)'(iec_pkg::KELVIN_OFFSET);
        m = k[iec_pkg::TEMP_W] ? (~k + 1'b1) : k;
        return m[iec_pkg::ABS_W-1:0];
    endfunction

    // The whole front advances unless its last stage is blocked by a full queue.
    assign adv         = !v_reg[3] || !queue_full;
    assign in_ch.ready = adv;
    assign push        = v_reg[3] && !queue_full;
    assign push_data   = w_reg;

    // Classify: sign and magnitude of the fourth-power difference.
    always_comb
    begin
        w_next.ta4 = pa_reg;
        w_next.neg = (po_reg < pa_reg);
        w_next.mag = w_next.neg ? (pa_reg - po_reg) : (po_reg - pa_reg);
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_ch.valid};
        end
    end

    // Payload stages: Kelvin, square, fourth power, classification.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ka_reg <= kelvin_abs(in_ch.ambient_temp);
            ko_reg <= kelvin_abs(in_ch.object_temp);
            sa_reg <= iec_pkg::SQ_W'(ka_reg) * iec_pkg::SQ_W'(ka_reg);
            so_reg <= iec_pkg::SQ_W'(ko_reg) * iec_pkg::SQ_W'(ko_reg);
            pa_reg <= iec_pkg::P4_W'(sa_reg) * iec_pkg::P4_W'(sa_reg);
            po_reg <= iec_pkg::P4_W'(so_reg) * iec_pkg::P4_W'(so_reg);
            w_reg  <= w_next;
        end
    end

endmodule

// ===== rtl/iec_queue.sv =====
// Short queue of classified items between the front and back parts.
// Depends on iec_pkg.
`timescale 1ns / 1ps

module iec_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  iec_pkg::work_t   push_data,
    output logic             full,
    input  logic             pop,
    output logic             avail,
    output iec_pkg::work_t   head
);

    iec_pkg::work_t                 mem_reg [0:iec_pkg::QUEUE_DEPTH-1];
    logic [iec_pkg::QPTR_W-1:0]     wr_reg, rd_reg;
    logic [iec_pkg::QPTR_W:0]       cnt_reg;

    assign full  = (cnt_reg == (iec_pkg::QPTR_W+1)'(iec_pkg::QUEUE_DEPTH));
    assign avail = (cnt_reg != '0);
    assign head  = mem_reg[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/iec_back.sv =====
// Back part: bit-serial pipelined division by the emissivity, radiance sum,
// two pipelined square roots and the Celsius output register. Depends on iec_pkg, iec_out_if.
`timescale 1ns / 1ps

module iec_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [iec_pkg::EMIS_W-1:0]   emis,
    input  logic                         avail,
    input  iec_pkg::work_t               head,
    output logic                         pop,
    iec_out_if.source                    out_ch
);

    localparam int DW  = iec_pkg::DIV_W;
    localparam int EW  = iec_pkg::EMIS_W;
    localparam int PW  = iec_pkg::POWER_WIDTH;
    localparam int R1  = iec_pkg::ROOT1_W;
    localparam int R2  = iec_pkg::ROOT2_W;
    localparam int RW1 = R1 + 3;
    localparam int RW2 = R2 + 3;

    logic en;

    // Divider stages.
    logic [DW:0]                 dv_reg, dneg_reg;
    logic [EW-1:0]               drem_reg  [0:DW];
    logic [DW-1:0]               ddq_reg   [0:DW];
    logic [iec_pkg::P4_W-1:0]    dta_reg   [0:DW];
    logic [EW-1:0]               drem_next [1:DW];
    logic [DW-1:0]               ddq_next  [1:DW];
    logic [EW:0]                 dpart     [1:DW];
    logic                        dge       [1:DW];

    // Radiance sum.
    logic                        c_v_reg, c_inv_reg;
    logic [iec_pkg::SUM_W-1:0]   c_t_reg;
    logic [iec_pkg::SUM_W-1:0]   c_t_next;
    logic                        c_inv_next;

    // First root stages; stage 0 holds the clamped sum.
    logic [R1:0]                 s1v_reg, s1inv_reg;
    logic [PW-1:0]               s1rad_reg  [0:R1];
    logic [RW1-1:0]              s1rem_reg  [0:R1];
    logic [R1-1:0]               s1root_reg [0:R1];
    logic [RW1-1:0]              s1rs       [1:R1];
    logic [RW1-1:0]              s1trial    [1:R1];
    logic [PW-1:0]               s1rad0_next;

    // Second root stages.
    logic [R2:0]                 s2v_reg, s2inv_reg;
    logic [R1-1:0]               s2rad_reg  [0:R2];
    logic [RW2-1:0]              s2rem_reg  [0:R2];
    logic [R2-1:0]               s2root_reg [0:R2];
    logic [RW2-1:0]              s2rs       [1:R2];
    logic [RW2-1:0]              s2trial    [1:R2];

    // Output register.
    logic                        o_v_reg, o_inv_reg;
    logic [iec_pkg::TEMP_W-1:0]  o_temp_reg;
    logic [iec_pkg::TEMP_W-1:0]  o_temp_next;
    logic [R2+1:0]               diff;

    // The whole back part moves when the output register is free or being taken.
    assign en  = !o_v_reg || out_ch.ready;
    assign pop = en && avail;

    assign out_ch.valid          = o_v_reg;
    assign out_ch.corrected_temp = o_temp_reg;
    assign out_ch.invalid        = o_inv_reg;

    // One quotient bit per divider stage.
    always_comb
    begin
        for (int i = 1; i <= DW; i++)
        begin
            dpart[i]     = {drem_reg[i-1], ddq_reg[i-1][DW-1]};
            dge[i]       = (dpart[i] >= {1'b0, emis});
            drem_next[i] = dge[i] ? EW'(dpart[i] - {1'b0, emis}) : dpart[i][EW-1:0];
            ddq_next[i]  = {ddq_reg[i-1][DW-2:0], dge[i]};
        end
    end

    // Sum with the signed correction term; a negative or zero sum is invalid.
    always_comb
    begin
        c_t_next   = '0;
        c_inv_next = 1'b0;
        if (dneg_reg[DW])
        begin
            if (ddq_reg[DW] >= DW'(dta_reg[DW]))
            begin
                c_inv_next = 1'b1;
            end
            else
            begin
                c_t_next = iec_pkg::SUM_W'(dta_reg[DW]) - iec_pkg::SUM_W'(ddq_reg[DW]);
            end
        end
        else
        begin
            c_t_next = iec_pkg::SUM_W'(dta_reg[DW]) + iec_pkg::SUM_W'(ddq_reg[DW]);
        end
    end

    // Clamp the sum to the root's input width.
    always_comb
    begin
        if (|c_t_reg[iec_pkg::SUM_W-1:PW])
        begin
            s1rad0_next = '1;
        end
        else
        begin
            s1rad0_next = c_t_reg[PW-1:0];
        end
    end

    // Digit-by-digit square root steps.
    always_comb
    begin
        for (int i = 1; i <= R1; i++)
        begin
            s1rs[i]    = {s1rem_reg[i-1][RW1-3:0], s1rad_reg[i-1][PW-1 -: 2]};
            s1trial[i] = RW1'({s1root_reg[i-1], 2'b01});
        end
        for (int j = 1; j <= R2; j++)
        begin
            s2rs[j]    = {s2rem_reg[j-1][RW2-3:0], s2rad_reg[j-1][R1-1 -: 2]};
            s2trial[j] = RW2'({s2root_reg[j-1], 2'b01});
        end
    end

    // Back to Celsius with saturation at the top of the range.
    always_comb
    begin
        diff = (R2+2)'(s2root_reg[R2]) - (R2+2)'(iec_pkg::KELVIN_OFFSET);
        if (s2inv_reg[R2])
        begin
            o_temp_next = '0;
        end
        else if (!diff[R2+1] && (|diff[R2:iec_pkg::TEMP_W-1]))
        begin
            o_temp_next = iec_pkg::TEMP_W'(iec_pkg::OUT_MAX);
        end
        else
        begin
            o_temp_next = diff[iec_pkg::TEMP_W-1:0];
        end
    end

    // Valid bits along the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg  <= '0;
            c_v_reg <= 1'b0;
            s1v_reg <= '0;
            s2v_reg <= '0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg  <= {dv_reg[DW-1:0], avail};
            c_v_reg <= dv_reg[DW];
            s1v_reg <= {s1v_reg[R1-1:0], c_v_reg};
            s2v_reg <= {s2v_reg[R2-1:0], s1v_reg[R1]};
            o_v_reg <= s2v_reg[R2];
        end
    end

    // Payload along the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drem_reg[0] <= '0;
            ddq_reg[0]  <= {head.mag, {EW{1'b0}}};
            dta_reg[0]  <= head.ta4;
            dneg_reg[0] <= head.neg;
            for (int i = 1; i <= DW; i++)
            begin
                drem_reg[i] <= drem_next[i];
                ddq_reg[i]  <= ddq_next[i];
                dta_reg[i]  <= dta_reg[i-1];
                dneg_reg[i] <= dneg_reg[i-1];
            end

            c_t_reg   <= c_t_next;
            c_inv_reg <= c_inv_next;

            s1rad_reg[0]  <= s1rad0_next;
            s1rem_reg[0]  <= '0;
            s1root_reg[0] <= '0;
            s1inv_reg[0]  <= c_inv_reg || (c_t_reg == '0);
            for (int i = 1; i <= R1; i++)
            begin
                s1rad_reg[i] <= {s1rad_reg[i-1][PW-3:0], 2'b00};
                s1inv_reg[i] <= s1inv_reg[i-1];
                if (s1rs[i] >= s1trial[i])
                begin
                    s1rem_reg[i]  <= s1rs[i] - s1trial[i];
                    s1root_reg[i] <= {s1root_reg[i-1][R1-2:0], 1'b1};
                end
                else
                begin
                    s1rem_reg[i]  <= s1rs[i];
                    s1root_reg[i] <= {s1root_reg[i-1][R1-2:0], 1'b0};
                end
            end

            s2rad_reg[0]  <= s1root_reg[R1];
            s2rem_reg[0]  <= '0;
            s2root_reg[0] <= '0;
            s2inv_reg[0]  <= s1inv_reg[R1];
            for (int j = 1; j <= R2; j++)
            begin
                s2rad_reg[j] <= {s2rad_reg[j-1][R1-3:0], 2'b00};
                s2inv_reg[j] <= s2inv_reg[j-1];
                if (s2rs[j] >= s2trial[j])
                begin
                    s2rem_reg[j]  <= s2rs[j] - s2trial[j];
                    s2root_reg[j] <= {s2root_reg[j-1][R2-2:0], 1'b1};
                end
                else
                begin
                    s2rem_reg[j]  <= s2rs[j];
                    s2root_reg[j] <= {s2root_reg[j-1][R2-2:0], 1'b0};
                end
            end

            o_temp_reg <= o_temp_next;
            o_inv_reg  <= s2inv_reg[R2];
        end
    end

endmodule

// ===== rtl/ir_emissivity_correction_unit.sv =====
// Top level of the emissivity correction unit: configuration port, front, queue, back.
// Depends on iec_pkg, iec_in_if, iec_out_if, iec_front, iec_queue, iec_back.
`timescale 1ns / 1ps

// Usage:
// in_ch carries one beat per sample: ambient_temp and object_temp in 0.01 degC.
// out_ch returns one beat per input beat, in order: corrected_temp in 0.01 degC and
// invalid, set (with a zero temperature) when the radiance sum is not positive.
// Both channels transfer a beat when valid and ready are high at a clock edge.
// The emissivity register (Q0.16, offset 0) is written over the APB port; the user
// must write it only while idle, as the block does not enforce this. A value of zero
// acts as 1/65536. Reads return the current value. Throughput: one beat per cycle
// unless the output stalls. A beat passes a four-stage power front end, the division at
// one bit per stage (84 stages) and the two square-root pipelines (36 and 18 stages).
// A four-entry queue decouples the front from the back. When out_ch.ready is low and
// out_ch.valid is high, the back holds; the front takes beats until the queue fills.
// Reset (rst_n low) empties every stage and the queue and sets emissivity to 64225.

module ir_emissivity_correction_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    iec_in_if.sink        in_ch,
    iec_out_if.source     out_ch
);

    logic [iec_pkg::EMIS_W-1:0]  emis_reg;
    logic [iec_pkg::EMIS_W-1:0]  emis_eff;
    logic                        q_full, q_push, q_pop, q_avail;
    iec_pkg::work_t              q_in, q_head;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == iec_pkg::REG_EMISSIVITY) ? 32'(emis_reg) : '0;
    assign emis_eff = (emis_reg == '0) ? iec_pkg::EMIS_W'(1) : emis_reg;

    // Emissivity register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emis_reg <= iec_pkg::EMIS_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == iec_pkg::REG_EMISSIVITY))
        begin
            emis_reg <= pwdata[iec_pkg::EMIS_W-1:0];
        end
    end

    iec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (q_full),
        .push       (q_push),
        .push_data  (q_in)
    );

    iec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .avail      (q_avail),
        .head       (q_head)
    );

    iec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .emis       (emis_eff),
        .avail      (q_avail),
        .head       (q_head),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

endmodule

// ===== tb/tb_iec_checker.sv =====
// Checker for the emissivity correction unit: watches both channels, predicts and compares.
// Depends on iec_pkg, iec_in_if and iec_out_if.
`timescale 1ns / 1ps

module tb_iec_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] emissivity,
    iec_in_if           in_ch,
    iec_out_if          out_ch,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic signed [iec_pkg::TEMP_W-1:0] temp;
        logic                              invalid;
    } corrected_t;

    corrected_t expected_q[$];

    // Exact fourth power of the Kelvin value of a temperature in 0.01 degC.
    function automatic logic [127:0] kelvin_pow4(logic signed [16:0] c);
        longint       k;
        logic [127:0] a;
        k = longint'(c) + iec_pkg::KELVIN_OFFSET;
        if (k < 0)
        begin
            k = -k;
        end
        a = 128'(k);
        return a * a * a * a;
    endfunction

    // Floor of the square root of a wide value, bit by bit.
    function automatic logic [127:0] floor_sqrt(logic [127:0] t);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= t)
            begin
                r = c;
            end
        end
        return r;
    endfunction

    // Emissivity corrected temperature of one sample.
    function automatic corrected_t correct_temp(logic signed [16:0] amb,
                                                logic signed [16:0] obj,
                                                logic [15:0] emis);
        logic [127:0] ta4;
        logic [127:0] to4;
        logic [127:0] q;
        logic [127:0] t;
        logic [127:0] e;
        longint       root;
        corrected_t   r;
        ta4 = kelvin_pow4(amb);
        to4 = kelvin_pow4(obj);
        e = (emis == 0) ? 128'd1 : 128'(emis);
        r = '0;
        if (to4 < ta4)
        begin
            q = ((ta4 - to4) << 16) / e;
            if (q >= ta4)
            begin
                r.invalid = 1'b1;
                return r;
            end
            t = ta4 - q;
        end
        else
        begin
            q = ((to4 - ta4) << 16) / e;
            t = ta4 + q;
        end
        if (t == 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        if (t > (128'd1 << iec_pkg::POWER_WIDTH) - 1)
        begin
            t = (128'd1 << iec_pkg::POWER_WIDTH) - 1;
        end
        root = longint'(floor_sqrt(floor_sqrt(t))) - iec_pkg::KELVIN_OFFSET;
        if (root > iec_pkg::OUT_MAX)
        begin
            root = iec_pkg::OUT_MAX;
        end
        r.temp = root[16:0];
        return r;
    endfunction

    // Predict on each input beat, compare on each output beat.
    always @(posedge clk or negedge rst_n)
    begin
        corrected_t exp_r;
        if (!rst_n)
        begin
            expected_q.delete();
            errors       <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_q.push_back(correct_temp(in_ch.ambient_temp, in_ch.object_temp,
                                                  emissivity));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat temp=%0d invalid=%0b", $time,
                             out_ch.corrected_temp, out_ch.invalid);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.temp !== out_ch.corrected_temp
                        || exp_r.invalid !== out_ch.invalid)
                    begin
                        $display("%0t: mismatch expected temp=%0d invalid=%0b, got temp=%0d invalid=%0b",
                                 $time, exp_r.temp, exp_r.invalid,
                                 out_ch.corrected_temp, out_ch.invalid);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb_ir_emissivity_correction_unit.sv =====
// Testbench top for the emissivity correction unit: stimulus, APB writes and verdict.
// Depends on iec_pkg, iec_in_if, iec_out_if, the unit and tb_iec_checker.
`timescale 1ns / 1ps

module tb_ir_emissivity_correction_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [15:0] emissivity;
    int          errors;
    int          pending;
    int          results_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          beats_sent;
    int          idle_count;

    iec_in_if  in_ch ();
    iec_out_if out_ch ();

    ir_emissivity_correction_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    tb_iec_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .emissivity   (emissivity),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Receiver stalls at random at the current rate.
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no beat accepted and no APB access.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        begin
            idle_count <= 0;
        end
        else if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_count <= idle_count + 1;
        end
    end

    // Register write over APB, setup then access.
    task automatic write_emissivity(logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * iec_pkg::REG_EMISSIVITY);
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        emissivity = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one sample beat, with a random gap before it.
    // Valid stays high after the beat so that the next one can follow at once.
    task automatic send_sample(logic signed [16:0] amb, logic signed [16:0] obj);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.ambient_temp <= amb;
        in_ch.object_temp  <= obj;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
        @(negedge clk);
    endtask

    // Stop sending, then wait until every expected beat has come and the pipeline is quiet.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random sample: mostly the specified range, sometimes any 17-bit value.
    task automatic send_random();
        logic signed [16:0] a;
        logic signed [16:0] o;
        if ($urandom_range(9) == 0)
        begin
            a = 17'($urandom);
            o = 17'($urandom);
        end
        else
        begin
            a = 17'($signed($urandom_range(45000)) - 7000);
            o = 17'($signed($urandom_range(45000)) - 7000);
        end
        send_sample(a, o);
    endtask

    initial
    begin
        logic [15:0] emis_set[6];
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.ambient_temp = '0;
        in_ch.object_temp  = '0;
        emissivity    = iec_pkg::EMIS_RESET;
        send_idle_pct = 10;
        recv_idle_pct = 76;
        beats_sent    = 0;
        rst_n         = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed at reset emissivity: equal, cold and hot cases, then field extremes.
        send_sample(-17'sd7000, -17'sd7000);
        send_sample(17'sd38000, 17'sd38000);
        send_sample(-17'sd7000, 17'sd38000);
        send_sample(17'sd38000, -17'sd7000);
        send_sample(17'sd2500, 17'sd2500);
        send_sample(-17'sd27315, -17'sd27315);
        send_sample(-17'sd65536, 17'sd65535);
        send_sample(17'sd65535, -17'sd65536);
        send_sample(-17'sd30000, -17'sd65536);
        send_sample(17'sd0, 17'sd65535);
        drain();

        // Extreme emissivities: low drives the sum negative and the output to saturation.
        write_emissivity(16'd6554);
        send_sample(17'sd38000, -17'sd7000);
        send_sample(-17'sd7000, 17'sd38000);
        send_sample(17'sd65535, 17'sd65535);
        send_sample(17'sd2000, 17'sd1900);
        drain();
        write_emissivity(16'd0);
        send_sample(17'sd38000, -17'sd7000);
        send_sample(-17'sd7000, 17'sd38000);
        send_sample(17'sd100, 17'sd100);
        drain();
        write_emissivity(16'd65535);
        send_sample(-17'sd7000, 17'sd38000);
        send_sample(17'sd38000, -17'sd7000);
        drain();

        // Random phases over several emissivity settings and idling patterns.
        emis_set = '{16'd6554, 16'd65535, 16'd64225, 16'd32768, 16'd1, 16'd50000};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 10;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_emissivity(ph == 5 ? 16'($urandom) : emis_set[ph]);
            for (int i = 0; i < 130; i++)
            begin
                send_random();
            end
            drain();
        end

        $display("Sent %0d samples, checked %0d corrected beats over ten emissivity phases.",
                 beats_sent, results_seen);
        if (errors == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iec_pkg.sv
rtl/iec_in_if.sv
rtl/iec_out_if.sv
rtl/iec_front.sv
rtl/iec_queue.sv
rtl/iec_back.sv
rtl/ir_emissivity_correction_unit.sv
tb/tb_iec_checker.sv
tb/tb_ir_emissivity_correction_unit.sv
